// ===== src/rf_sweep_activity_monitor_defines.svh =====
// assertion macros for the rf sweep activity monitor
// used by the top level; no other dependencies
`ifndef RF_SWEEP_ACTIVITY_MONITOR_DEFINES_SVH
`define RF_SWEEP_ACTIVITY_MONITOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RSAM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RSAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rsam_pkg.sv =====
// shared types, constants and helpers for the rf sweep activity monitor
// no dependencies
`timescale 1ns / 1ps

package rsam_pkg;

    // field widths
    localparam int BIN_FIELD_W = 6;
    localparam int RSSI_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;
    localparam int BAR_W       = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSUAL_HOLD_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_GAP_MS    = 3'd7;

    // register reset values
    localparam logic signed [RSSI_W-1:0] SIGNAL_THRESH_RST = -8'sd75;
    localparam logic signed [RSSI_W-1:0] STRONG_THRESH_RST = -8'sd45;
    localparam logic [MS_W-1:0] BURST_LIMIT_RST     = 16'd30;
    localparam logic [MS_W-1:0] WINDOW_MS_RST       = 16'd1000;
    localparam logic [MS_W-1:0] CONTINUOUS_MS_RST   = 16'd3000;
    localparam logic [MS_W-1:0] UNUSUAL_HOLD_MS_RST = 16'd3000;
    localparam logic [MS_W-1:0] ALERT_GAP_MS_RST    = 16'd2000;

    // peak hold floor
    localparam logic signed [RSSI_W-1:0] PEAK_RESET = -8'sd127;

    // bar scaling: (peak + 110) * 100 / 80
    localparam logic signed [9:0] BAR_OFFSET = 10'sd110;
    localparam logic signed [9:0] BAR_SPAN   = 10'sd80;
    localparam logic [BAR_W-1:0]  BAR_FULL   = 7'd100;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_SIGNAL     = 3'd1,
        ST_STRONG     = 3'd2,
        ST_CONTINUOUS = 3'd3,
        ST_UNUSUAL    = 3'd4
    } t_status;

    // one row of per-bin state
    typedef struct packed {
        logic signed [RSSI_W-1:0] peak;
        logic [CNT_W-1:0]         hits;
        logic                     active;
        logic [TIME_W-1:0]        start;
    } t_bin_row;

    // row write request
    typedef struct packed {
        logic                   en;
        logic [BIN_FIELD_W-1:0] addr;
        t_bin_row               data;
    } t_bin_wr;

    // peak hold to 0..100; 100/80 is 5/4, done as a multiply by 5 and a shift
    function automatic logic [BAR_W-1:0] bar_of_peak(input logic signed [RSSI_W-1:0] peak);
        logic signed [9:0] lvl;
        logic [8:0]        scaled;
        begin
            lvl    = $signed({{2{peak[RSSI_W-1]}}, peak}) + BAR_OFFSET;
            scaled = {2'b00, lvl[6:0]} * 9'd5;
            if (lvl <= 10'sd0) begin
                bar_of_peak = '0;
            end else if (lvl >= BAR_SPAN) begin
                bar_of_peak = BAR_FULL;
            end else begin
                bar_of_peak = scaled[8:2];
            end
        end
    endfunction

endpackage

// ===== src/rsam_ifs.sv =====
// handshake channels of the rf sweep activity monitor: samples, results, register writes
// depends on rsam_pkg
`timescale 1ns / 1ps

interface rsam_sample_if import rsam_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [TIME_W-1:0]        now_ms;
    logic signed [RSSI_W-1:0] rssi;

    modport source (output valid, op, now_ms, rssi, input ready);
    modport sink   (input valid, op, now_ms, rssi, output ready);
endinterface

interface rsam_result_if import rsam_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [BIN_FIELD_W-1:0]   bin;
    logic [2:0]               status;
    logic                     warning;
    logic                     alert;
    logic                     new_event;
    logic [BAR_W-1:0]         bar_level;
    logic signed [RSSI_W-1:0] peak_rssi;
    logic [BIN_FIELD_W-1:0]   peak_bin;
    logic [BIN_FIELD_W-1:0]   busiest_bin;
    logic [CNT_W-1:0]         event_count;
    logic [TIME_W-1:0]        duration_ms;

    modport source (output valid, bin, status, warning, alert, new_event, bar_level,
                    peak_rssi, peak_bin, busiest_bin, event_count, duration_ms,
                    input ready);
    modport sink   (input valid, bin, status, warning, alert, new_event, bar_level,
                    peak_rssi, peak_bin, busiest_bin, event_count, duration_ms,
                    output ready);
endinterface

interface rsam_cfg_if import rsam_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rsam_bin_store.sv =====
// per-bin state memory: peak hold, hit count, activity flag, start time
// registered read with write-to-read forwarding and per-row valid bits; uses rsam_pkg
`timescale 1ns / 1ps

module rsam_bin_store
    import rsam_pkg::*;
#(
    parameter int NUM_BINS = 41
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [BIN_FIELD_W-1:0] i_rd_addr,
    input  t_bin_wr                i_wr,
    input  logic                   i_clr_peaks,
    output t_bin_row               o_rd_row
);

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    t_bin_row            r_mem [NUM_BINS];
    t_bin_row            r_rd_data;
    t_bin_row            r_byp_data;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_byp_vld;
    logic [NUM_BINS-1:0] r_pk_vld;
    logic [NUM_BINS-1:0] r_row_vld;

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_idx = i_rd_addr[IDX_W-1:0];
    assign wr_idx = i_wr.addr[IDX_W-1:0];

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[rd_idx];
            r_byp_data <= i_wr.data;
            r_rd_idx   <= rd_idx;
        end
    end

    // forwarding flag: row written in the same cycle it was read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_vld <= i_wr.en && (wr_idx == rd_idx);
        end
    end

    // valid bits: peaks cleared by reset or clear, rows by reset only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_vld  <= '0;
            r_row_vld <= '0;
        end else if (i_clr_peaks) begin
            r_pk_vld <= '0;
        end else if (i_wr.en) begin
            r_pk_vld[wr_idx]  <= 1'b1;
            r_row_vld[wr_idx] <= 1'b1;
        end
    end

    // read data with forwarding and reset values for unwritten rows
    always_comb begin
        if (r_byp_vld) begin
            o_rd_row = r_byp_data;
        end else begin
            o_rd_row = r_rd_data;
            if (!r_pk_vld[r_rd_idx]) begin
                o_rd_row.peak = PEAK_RESET;
            end
            if (!r_row_vld[r_rd_idx]) begin
                o_rd_row.hits   = '0;
                o_rd_row.active = 1'b0;
                o_rd_row.start  = '0;
            end
        end
    end

endmodule

// ===== src/rf_sweep_activity_monitor.sv =====
// rf sweep activity monitor: an input register with memory read at the accept edge,
// then one compute stage into the result register.
// throughput one item per cycle; a full result register that is not taken stalls
// the compute stage, and a clear request passes without producing a result.
// synchronous active-low reset clears the control and tracking state at once; per-bin rows are marked
// invalid by valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "rf_sweep_activity_monitor_defines.svh"

// top level: bin sequencing, event tracking, status and alert logic
// depends on rsam_pkg, rsam_ifs and rsam_bin_store
module rf_sweep_activity_monitor
    import rsam_pkg::*;
#(
    parameter int NUM_BINS = 41
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsam_sample_if.sink   i_sample,
    rsam_result_if.source o_result,
    rsam_cfg_if.sink      i_cfg
);

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

    // configuration registers
    logic                     r_watch;
    logic signed [RSSI_W-1:0] r_sig_thr;
    logic signed [RSSI_W-1:0] r_strong_thr;
    logic [MS_W-1:0]          r_burst;
    logic [MS_W-1:0]          r_window;
    logic [MS_W-1:0]          r_cont;
    logic [MS_W-1:0]          r_hold;
    logic [MS_W-1:0]          r_gap;

    // input stage
    logic                     r_in_valid;
    logic                     r_in_op;
    logic [TIME_W-1:0]        r_in_now;
    logic signed [RSSI_W-1:0] r_in_rssi;
    logic [IDX_W-1:0]         r_in_bin;
    logic [IDX_W-1:0]         r_cur_bin, n_cur_bin;

    // tracking state
    logic signed [RSSI_W-1:0] r_ovp, n_ovp;
    logic [IDX_W-1:0]         r_ovp_bin, n_ovp_bin;
    logic [IDX_W-1:0]         r_top_bin, n_top_bin;
    logic [CNT_W-1:0]         r_top_hits, n_top_hits;
    logic [CNT_W-1:0]         r_total, n_total;
    logic [TIME_W-1:0]        r_last_dur, n_last_dur;
    logic [TIME_W-1:0]        r_win_start, n_win_start;
    logic [CNT_W-1:0]         r_win_events, n_win_events;
    logic                     r_unusual, n_unusual;
    logic [TIME_W-1:0]        r_unusual_start, n_unusual_start;
    logic [TIME_W-1:0]        r_last_alert, n_last_alert;
    t_status                  r_prev_status, n_prev_status;

    // result register
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_bin;
    t_status                  r_out_status;
    logic                     r_out_warning;
    logic                     r_out_alert;
    logic                     r_out_new_event;
    logic [BAR_W-1:0]         r_out_bar;

    // snapshot of the running totals, taken with the result
    logic signed [RSSI_W-1:0] r_ovp_out;
    logic [IDX_W-1:0]         r_ovp_bin_out;
    logic [IDX_W-1:0]         r_top_bin_out;
    logic [CNT_W-1:0]         r_total_out;
    logic [TIME_W-1:0]        r_last_dur_out;

    // compute stage signals
    logic                     in_accept;
    logic                     fire;
    logic                     fire_sample;
    logic                     fire_clear;
    t_bin_row                 rd_row;
    t_bin_wr                  wr_req;
    logic signed [RSSI_W-1:0] peak_new;
    logic                     sig;
    logic                     new_ev;
    logic [CNT_W-1:0]         hits_new;
    logic [TIME_W-1:0]        start_new;
    logic [CNT_W-1:0]         win_ev_inc;
    logic [TIME_W-1:0]        win_age;
    logic [TIME_W-1:0]        unusual_age;
    logic [TIME_W-1:0]        alert_age;
    t_status                  status;
    logic                     warning;
    logic                     alert;

    // handshakes
    assign fire        = r_in_valid && (r_in_op || !r_out_valid || o_result.ready);
    assign fire_sample = fire && !r_in_op;
    assign fire_clear  = fire && r_in_op;
    assign i_sample.ready = !r_in_valid || fire;
    assign in_accept   = i_sample.valid && i_sample.ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watch      <= 1'b0;
            r_sig_thr    <= SIGNAL_THRESH_RST;
            r_strong_thr <= STRONG_THRESH_RST;
            r_burst      <= BURST_LIMIT_RST;
            r_window     <= WINDOW_MS_RST;
            r_cont       <= CONTINUOUS_MS_RST;
            r_hold       <= UNUSUAL_HOLD_MS_RST;
            r_gap        <= ALERT_GAP_MS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WATCH_MODE:      r_watch      <= i_cfg.data[0];
                CFG_SIGNAL_THRESH:   r_sig_thr    <= i_cfg.data[RSSI_W-1:0];
                CFG_STRONG_THRESH:   r_strong_thr <= i_cfg.data[RSSI_W-1:0];
                CFG_BURST_LIMIT:     r_burst      <= i_cfg.data;
                CFG_WINDOW_MS:       r_window     <= i_cfg.data;
                CFG_CONTINUOUS_MS:   r_cont       <= i_cfg.data;
                CFG_UNUSUAL_HOLD_MS: r_hold       <= i_cfg.data;
                CFG_ALERT_GAP_MS:    r_gap        <= i_cfg.data;
                default:             r_watch      <= r_watch;
            endcase
        end
    end

    // bin sequencing: each accepted sample takes the current bin
    always_comb begin
        n_cur_bin = r_cur_bin;
        if (in_accept && !i_sample.op) begin
            if (r_watch) begin
                n_cur_bin = '0;
            end else if (r_cur_bin == LAST_BIN) begin
                n_cur_bin = '0;
            end else begin
                n_cur_bin = r_cur_bin + 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cur_bin  <= '0;
        end else begin
            r_cur_bin <= n_cur_bin;
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= i_sample.op;
            r_in_now  <= i_sample.now_ms;
            r_in_rssi <= i_sample.rssi;
            r_in_bin  <= r_cur_bin;
        end
    end

    // per-bin store
    rsam_bin_store #(
        .NUM_BINS (NUM_BINS)
    ) u_bins (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_accept),
        .i_rd_addr   (BIN_FIELD_W'(r_cur_bin)),
        .i_wr        (wr_req),
        .i_clr_peaks (fire_clear),
        .o_rd_row    (rd_row)
    );

    // per-sample update of the bin row and the tracking state
    always_comb begin
        n_ovp           = r_ovp;
        n_ovp_bin       = r_ovp_bin;
        n_top_bin       = r_top_bin;
        n_top_hits      = r_top_hits;
        n_total         = r_total;
        n_last_dur      = r_last_dur;
        n_win_start     = r_win_start;
        n_win_events    = r_win_events;
        n_unusual       = r_unusual;
        n_unusual_start = r_unusual_start;
        n_last_alert    = r_last_alert;
        n_prev_status   = r_prev_status;

        // bin row
        peak_new  = (r_in_rssi > rd_row.peak) ? r_in_rssi : rd_row.peak;
        sig       = r_in_rssi >= r_sig_thr;
        hits_new  = sig ? rd_row.hits + 1'b1 : rd_row.hits;
        new_ev    = sig && !rd_row.active;
        start_new = new_ev ? r_in_now : rd_row.start;

        wr_req.en          = fire_sample;
        wr_req.addr        = BIN_FIELD_W'(r_in_bin);
        wr_req.data.peak   = peak_new;
        wr_req.data.hits   = hits_new;
        wr_req.data.active = sig;
        wr_req.data.start  = start_new;

        // overall peak
        if (r_in_rssi > r_ovp) begin
            n_ovp     = r_in_rssi;
            n_ovp_bin = r_in_bin;
        end

        // busiest bin, its hit count mirrored in a register
        if (sig) begin
            if (r_in_bin == r_top_bin) begin
                n_top_hits = hits_new;
            end else if (hits_new > r_top_hits) begin
                n_top_bin  = r_in_bin;
                n_top_hits = hits_new;
            end
        end

        // event counts and signal duration
        win_ev_inc = r_win_events + CNT_W'(new_ev);
        if (new_ev) begin
            n_total = r_total + 1'b1;
        end
        if (sig) begin
            n_last_dur = r_in_now - start_new;
        end

        // status class before the unusual override
        if (!sig) begin
            status = ST_NONE;
        end else if (n_last_dur > TIME_W'(r_cont)) begin
            status = ST_CONTINUOUS;
        end else if (r_in_rssi >= r_strong_thr) begin
            status = ST_STRONG;
        end else begin
            status = ST_SIGNAL;
        end

        // counting window
        win_age      = r_in_now - r_win_start;
        n_win_events = win_ev_inc;
        if (win_age >= TIME_W'(r_window)) begin
            if (win_ev_inc > CNT_W'(r_burst)) begin
                n_unusual       = 1'b1;
                n_unusual_start = r_in_now;
            end
            n_win_events = '0;
            n_win_start  = r_in_now;
        end

        // unusual hold time
        unusual_age = r_in_now - n_unusual_start;
        if (n_unusual && (unusual_age >= TIME_W'(r_hold))) begin
            n_unusual = 1'b0;
        end
        if (n_unusual) begin
            status = ST_UNUSUAL;
        end

        // rate-limited alert on entering a warning class
        warning   = (status == ST_CONTINUOUS) || (status == ST_UNUSUAL);
        alert_age = r_in_now - r_last_alert;
        alert     = warning && (status != r_prev_status) && (alert_age >= TIME_W'(r_gap));
        if (alert) begin
            n_last_alert = r_in_now;
        end
        n_prev_status = status;

        // a clear request only touches the peak holds
        if (fire_clear) begin
            n_ovp        = PEAK_RESET;
            n_ovp_bin    = '0;
            n_top_bin    = r_top_bin;
            n_top_hits   = r_top_hits;
            n_total      = r_total;
            n_last_dur   = r_last_dur;
            n_win_start  = r_win_start;
            n_win_events = r_win_events;
            n_unusual    = r_unusual;
            n_unusual_start = r_unusual_start;
            n_last_alert = r_last_alert;
            n_prev_status = r_prev_status;
        end else if (!fire_sample) begin
            n_ovp        = r_ovp;
            n_ovp_bin    = r_ovp_bin;
            n_top_bin    = r_top_bin;
            n_top_hits   = r_top_hits;
            n_total      = r_total;
            n_last_dur   = r_last_dur;
            n_win_start  = r_win_start;
            n_win_events = r_win_events;
            n_unusual    = r_unusual;
            n_unusual_start = r_unusual_start;
            n_last_alert = r_last_alert;
            n_prev_status = r_prev_status;
        end
    end

    // tracking state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovp           <= PEAK_RESET;
            r_ovp_bin       <= '0;
            r_top_bin       <= '0;
            r_top_hits      <= '0;
            r_total         <= '0;
            r_last_dur      <= '0;
            r_win_start     <= '0;
            r_win_events    <= '0;
            r_unusual       <= 1'b0;
            r_unusual_start <= '0;
            r_last_alert    <= '0;
            r_prev_status   <= ST_NONE;
        end else begin
            r_ovp           <= n_ovp;
            r_ovp_bin       <= n_ovp_bin;
            r_top_bin       <= n_top_bin;
            r_top_hits      <= n_top_hits;
            r_total         <= n_total;
            r_last_dur      <= n_last_dur;
            r_win_start     <= n_win_start;
            r_win_events    <= n_win_events;
            r_unusual       <= n_unusual;
            r_unusual_start <= n_unusual_start;
            r_last_alert    <= n_last_alert;
            r_prev_status   <= n_prev_status;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_sample) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_sample) begin
            r_out_bin       <= r_in_bin;
            r_out_status    <= status;
            r_out_warning   <= warning;
            r_out_alert     <= alert;
            r_out_new_event <= new_ev;
            r_out_bar       <= bar_of_peak(peak_new);
        end
    end

    // result fields; running totals come from the snapshot taken with the result
    assign o_result.valid       = r_out_valid;
    assign o_result.bin         = BIN_FIELD_W'(r_out_bin);
    assign o_result.status      = r_out_status;
    assign o_result.warning     = r_out_warning;
    assign o_result.alert       = r_out_alert;
    assign o_result.new_event   = r_out_new_event;
    assign o_result.bar_level   = r_out_bar;
    assign o_result.peak_rssi   = r_ovp_out;
    assign o_result.peak_bin    = BIN_FIELD_W'(r_ovp_bin_out);
    assign o_result.busiest_bin = BIN_FIELD_W'(r_top_bin_out);
    assign o_result.event_count = r_total_out;
    assign o_result.duration_ms = r_last_dur_out;

    // snapshot registers
    always_ff @(posedge i_clk) begin
        if (fire_sample) begin
            r_ovp_out      <= n_ovp;
            r_ovp_bin_out  <= n_ovp_bin;
            r_top_bin_out  <= n_top_bin;
            r_total_out    <= n_total;
            r_last_dur_out <= n_last_dur;
        end
    end

    // checks
    `RSAM_ASSERT_NOW(a_alert_needs_warning, i_clk, i_rst_n, o_result.valid && o_result.alert, o_result.warning, "alert without warning status")
    `RSAM_ASSERT_NOW(a_event_is_signal, i_clk, i_rst_n, o_result.valid && o_result.new_event, o_result.status != ST_NONE, "new event on a quiet sample")
    `RSAM_ASSERT_NEXT(a_watch_bin_zero, i_clk, i_rst_n, in_accept && !i_sample.op && r_watch, r_cur_bin == '0, "watch mode left bin zero")
    `RSAM_ASSERT_NEXT(a_stall_holds_item, i_clk, i_rst_n, r_in_valid && !r_in_op && r_out_valid && !o_result.ready, r_in_valid && $stable(r_in_now) && $stable(r_in_bin), "stalled sample lost")

endmodule

// ===== tb/tb_rf_sweep_activity_monitor.sv =====
`timescale 1ns / 1ps
// self-checking testbench for rf_sweep_activity_monitor: directed table, then random sweeps
// depends on rsam_pkg, rsam_ifs and the rf_sweep_activity_monitor rtl

module tb_rf_sweep_activity_monitor;
    import rsam_pkg::*;

    localparam int N_BINS       = 41;
    localparam int PERIOD_NS    = 20;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 160;
    localparam int SETTLE       = 6;
    localparam int TAIL_LIMIT   = 20000;
    localparam int PEAK_FLOOR   = -127;
    localparam int BAR_PLUS     = 110;
    localparam int BAR_MUL      = 100;
    localparam int BAR_DIV      = 80;
    localparam int BAR_TOP      = 100;
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // one activity report as the block should produce it
    typedef struct {
        logic [BIN_FIELD_W-1:0]   bin;
        t_status                  status;
        logic                     warning;
        logic                     alert;
        logic                     new_event;
        logic [BAR_W-1:0]         bar_level;
        logic signed [RSSI_W-1:0] peak_rssi;
        logic [BIN_FIELD_W-1:0]   peak_bin;
        logic [BIN_FIELD_W-1:0]   busiest_bin;
        logic [CNT_W-1:0]         event_count;
        logic [TIME_W-1:0]        duration_ms;
    } t_activity_report;

    // one sample request, with optional hand-typed expectation
    typedef struct {
        logic                     op;
        logic [TIME_W-1:0]        now_ms;
        logic signed [RSSI_W-1:0] rssi;
        bit                       pinned;
        logic [BIN_FIELD_W-1:0]   bin;
        t_status                  status;
        logic                     new_event;
        logic [BAR_W-1:0]         bar_level;
    } t_sample_req;

    // one register setting and how many random requests run under it
    typedef struct {
        logic                     watch;
        logic signed [RSSI_W-1:0] sig_th;
        logic signed [RSSI_W-1:0] strong_th;
        logic [MS_W-1:0]          burst;
        logic [MS_W-1:0]          window;
        logic [MS_W-1:0]          cont;
        logic [MS_W-1:0]          hold;
        logic [MS_W-1:0]          gap;
        logic [TIME_W-1:0]        start_ms;
        int                       items;
    } t_sweep_setup;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsam_sample_if sample_ch ();
    rsam_result_if report_ch ();
    rsam_cfg_if    reg_ch ();

    rf_sweep_activity_monitor #(
        .NUM_BINS (N_BINS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (report_ch),
        .i_cfg    (reg_ch)
    );

    always #(PERIOD_NS / 2) i_clk = ~i_clk;

    // predictor copy of the register file
    logic                     cfg_watch;
    logic signed [RSSI_W-1:0] cfg_sig;
    logic signed [RSSI_W-1:0] cfg_strong;
    logic [MS_W-1:0]          cfg_burst, cfg_window, cfg_cont, cfg_hold, cfg_gap;

    // predictor copy of the monitor state
    int                pk_hold   [N_BINS];
    logic [CNT_W-1:0]  hit_cnt   [N_BINS];
    bit                lit       [N_BINS];
    logic [TIME_W-1:0] lit_since [N_BINS];
    int                cur_bin, top_peak, top_peak_bin, busy_bin;
    logic [CNT_W-1:0]  total_ev, win_count;
    logic [TIME_W-1:0] dur_last, win_start, odd_since, alert_at;
    bit                odd_flag;
    t_status           prev_status;

    t_activity_report pending_reports [$];
    t_sample_req      directed_rows [$];
    t_sweep_setup     setups [$];
    t_activity_report head;

    int          mismatches = 0;
    int          cycle_count = 0;
    int          samples_taken = 0;
    int          reports_seen = 0;
    int          n_events = 0, n_cont = 0, n_odd = 0, n_alert = 0;
    int          stall_left = 0;
    int          run_left = 0;
    bit          quiet_run = 1'b0;
    bit          hold_req = 1'b0;
    logic [TIME_W-1:0] clock_ms;

    // mismatch report: one line, counted
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
        mismatches++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
    endtask

    // peak holds back to the floor
    function automatic void clear_peak_holds();
        for (int i = 0; i < N_BINS; i++) pk_hold[i] = PEAK_FLOOR;
        top_peak     = PEAK_FLOOR;
        top_peak_bin = 0;
    endfunction

    function automatic void reset_predictor();
        cfg_watch  = 1'b0;
        cfg_sig    = SIGNAL_THRESH_RST;
        cfg_strong = STRONG_THRESH_RST;
        cfg_burst  = BURST_LIMIT_RST;
        cfg_window = WINDOW_MS_RST;
        cfg_cont   = CONTINUOUS_MS_RST;
        cfg_hold   = UNUSUAL_HOLD_MS_RST;
        cfg_gap    = ALERT_GAP_MS_RST;
        clear_peak_holds();
        for (int i = 0; i < N_BINS; i++) begin
            hit_cnt[i]   = '0;
            lit[i]       = 1'b0;
            lit_since[i] = '0;
        end
        cur_bin     = 0;
        busy_bin    = 0;
        total_ev    = '0;
        win_count   = '0;
        dur_last    = '0;
        win_start   = '0;
        odd_since   = '0;
        alert_at    = '0;
        odd_flag    = 1'b0;
        prev_status = ST_NONE;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WATCH_MODE:      cfg_watch  = val[0];
            CFG_SIGNAL_THRESH:   cfg_sig    = val[RSSI_W-1:0];
            CFG_STRONG_THRESH:   cfg_strong = val[RSSI_W-1:0];
            CFG_BURST_LIMIT:     cfg_burst  = val;
            CFG_WINDOW_MS:       cfg_window = val;
            CFG_CONTINUOUS_MS:   cfg_cont   = val;
            CFG_UNUSUAL_HOLD_MS: cfg_hold   = val;
            CFG_ALERT_GAP_MS:    cfg_gap    = val;
            default: ;
        endcase
    endfunction

    // works out the report for one sample and advances the state
    function automatic t_activity_report predict_activity(input logic [TIME_W-1:0] now,
                                                          input logic signed [RSSI_W-1:0] rssi);
        t_activity_report  rep;
        int                b, r, sig_i, strong_i, bar;
        bit                hot, fresh, warn, fire;
        t_status           st;
        logic [TIME_W-1:0] dt;
        b        = cur_bin;
        r        = rssi;
        sig_i    = cfg_sig;
        strong_i = cfg_strong;
        fire     = 1'b0;

        // peak holds
        if (r > pk_hold[b]) pk_hold[b] = r;
        if (r > top_peak) begin
            top_peak     = r;
            top_peak_bin = b;
        end

        // hit counting and busiest bin
        hot = (r >= sig_i);
        if (hot) begin
            hit_cnt[b] = hit_cnt[b] + 1'b1;
            if (hit_cnt[b] > hit_cnt[busy_bin]) busy_bin = b;
        end

        // rising edge of activity on this bin
        fresh = hot && !lit[b];
        if (fresh) begin
            lit_since[b] = now;
            total_ev     = total_ev + 1'b1;
            win_count    = win_count + 1'b1;
        end
        if (hot) dur_last = now - lit_since[b];

        if (!hot) st = ST_NONE;
        else if (dur_last > {16'd0, cfg_cont}) st = ST_CONTINUOUS;
        else if (r >= strong_i) st = ST_STRONG;
        else st = ST_SIGNAL;

        // event window closes and may raise the unusual flag
        dt = now - win_start;
        if (dt >= {16'd0, cfg_window}) begin
            if (win_count > {16'd0, cfg_burst}) begin
                odd_flag  = 1'b1;
                odd_since = now;
            end
            win_count = '0;
            win_start = now;
        end
        dt = now - odd_since;
        if (odd_flag && dt >= {16'd0, cfg_hold}) odd_flag = 1'b0;
        if (odd_flag) st = ST_UNUSUAL;

        // rate-limited alert on entering a warning class
        warn = (st == ST_CONTINUOUS) || (st == ST_UNUSUAL);
        dt   = now - alert_at;
        if (warn && st != prev_status && dt >= {16'd0, cfg_gap}) begin
            fire     = 1'b1;
            alert_at = now;
        end
        prev_status = st;
        lit[b]      = hot;

        bar = (pk_hold[b] + BAR_PLUS) * BAR_MUL / BAR_DIV;
        if (bar < 0) bar = 0;
        if (bar > BAR_TOP) bar = BAR_TOP;

        rep.bin         = BIN_FIELD_W'(b);
        rep.status      = st;
        rep.warning     = warn;
        rep.alert       = fire;
        rep.new_event   = fresh;
        rep.bar_level   = BAR_W'(bar);
        rep.peak_rssi   = RSSI_W'(top_peak);
        rep.peak_bin    = BIN_FIELD_W'(top_peak_bin);
        rep.busiest_bin = BIN_FIELD_W'(busy_bin);
        rep.event_count = total_ev;
        rep.duration_ms = dur_last;

        cur_bin = cfg_watch ? 0 : ((b + 1) % N_BINS);
        return rep;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (quiet_run || r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int pick_rssi(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // random request: signal runs, above/below threshold, noise, extremes
    function automatic t_sample_req make_random_request();
        t_sample_req req;
        int          r, sig_i, v;
        sig_i = cfg_sig;
        r     = $urandom_range(99);
        if (r < 5) clock_ms = clock_ms;
        else if (r < 75) clock_ms = clock_ms + $urandom_range(60);
        else if (r < 92) clock_ms = clock_ms + $urandom_range(600, 61);
        else if (r < 98) clock_ms = clock_ms + $urandom_range(5000, 601);
        else clock_ms = $urandom();

        r = $urandom_range(99);
        if (run_left > 0) begin
            run_left--;
            v = pick_rssi(sig_i, 127);
        end else if (r < 8) begin
            run_left = $urandom_range(40, 5);
            v = pick_rssi(sig_i, 127);
        end else if (r < 40) begin
            v = pick_rssi(sig_i, 127);
        end else if (r < 75 && sig_i > -128) begin
            v = pick_rssi(-128, sig_i - 1);
        end else if (r < 93) begin
            v = pick_rssi(-128, 127);
        end else begin
            v = ($urandom_range(1) == 0) ? -128 : 127;
        end

        req.op        = ($urandom_range(99) < 3) ? OP_CLEAR : OP_SAMPLE;
        req.now_ms    = clock_ms;
        req.rssi      = RSSI_W'(v);
        req.pinned    = 1'b0;
        req.bin       = '0;
        req.status    = ST_NONE;
        req.new_event = 1'b0;
        req.bar_level = '0;
        return req;
    endfunction

    task automatic add_row(input logic op, input logic [TIME_W-1:0] now, input int rssi,
                           input bit pinned, input int bin, input t_status st,
                           input logic ne, input int bar);
        t_sample_req req;
        req.op        = op;
        req.now_ms    = now;
        req.rssi      = RSSI_W'(rssi);
        req.pinned    = pinned;
        req.bin       = BIN_FIELD_W'(bin);
        req.status    = st;
        req.new_event = ne;
        req.bar_level = BAR_W'(bar);
        directed_rows.push_back(req);
    endtask

    task automatic add_setup(input logic watch, input int sig_th, input int strong_th,
                             input int burst, input int window, input int cont,
                             input int hold, input int gap, input logic [TIME_W-1:0] start,
                             input int items);
        t_sweep_setup s;
        s.watch     = watch;
        s.sig_th    = RSSI_W'(sig_th);
        s.strong_th = RSSI_W'(strong_th);
        s.burst     = MS_W'(burst);
        s.window    = MS_W'(window);
        s.cont      = MS_W'(cont);
        s.hold      = MS_W'(hold);
        s.gap       = MS_W'(gap);
        s.start_ms  = start;
        s.items     = items;
        setups.push_back(s);
    endtask

    // offers one request, entered and left at a falling edge
    task automatic send_request(input t_sample_req req);
        int               n;
        t_activity_report rep;
        n = idle_len();
        if (n > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.op     <= req.op;
        sample_ch.now_ms <= req.now_ms;
        sample_ch.rssi   <= req.rssi;
        do @(posedge i_clk); while (!sample_ch.ready);
        samples_taken++;
        if (req.op == OP_CLEAR) begin
            clear_peak_holds();
        end else begin
            rep = predict_activity(req.now_ms, req.rssi);
            if (req.pinned) begin
                rep.bin       = req.bin;
                rep.status    = req.status;
                rep.new_event = req.new_event;
                rep.bar_level = req.bar_level;
            end
            pending_reports.push_back(rep);
        end
        if ($urandom_range(99) < 3) quiet_run = !quiet_run;
        @(negedge i_clk);
    endtask

    // register write; leaves valid high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        apply_register(idx, val);
        @(negedge i_clk);
    endtask

    // wait until every report is in, plus room for a clear still in flight
    task automatic drain_reports();
        sample_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic run_setup(input t_sweep_setup s);
        drain_reports();
        cfg_write(CFG_WATCH_MODE, {15'd0, s.watch});
        cfg_write(CFG_SIGNAL_THRESH, {8'd0, s.sig_th});
        cfg_write(CFG_STRONG_THRESH, {8'd0, s.strong_th});
        cfg_write(CFG_BURST_LIMIT, s.burst);
        cfg_write(CFG_WINDOW_MS, s.window);
        cfg_write(CFG_CONTINUOUS_MS, s.cont);
        cfg_write(CFG_UNUSUAL_HOLD_MS, s.hold);
        cfg_write(CFG_ALERT_GAP_MS, s.gap);
        reg_ch.valid <= 1'b0;
        clock_ms = s.start_ms;
        run_left = 0;
        for (int k = 0; k < s.items; k++) send_request(make_random_request());
    endtask

    // receiver: random stalls, and the long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_req) begin
            report_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            report_ch.ready <= 1'b0;
        end else begin
            stall_left = idle_len();
            report_ch.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // long hold-off so the block fills and back-pressures its input
    initial begin
        wait (samples_taken >= HOLD_AFTER);
        @(posedge i_clk);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_req = 1'b0;
    end

    // report checker against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("report with nothing pending", 32'(report_ch.bin), 32'd0);
            end else begin
                head = pending_reports.pop_front();
                reports_seen++;
                if (head.new_event) n_events++;
                if (head.status == ST_CONTINUOUS) n_cont++;
                if (head.status == ST_UNUSUAL) n_odd++;
                if (head.alert) n_alert++;
                if (report_ch.bin !== head.bin)
                    flag_mismatch("bin", 32'(report_ch.bin), 32'(head.bin));
                if (report_ch.status !== head.status)
                    flag_mismatch("status", 32'(report_ch.status), 32'(head.status));
                if (report_ch.warning !== head.warning)
                    flag_mismatch("warning", 32'(report_ch.warning), 32'(head.warning));
                if (report_ch.alert !== head.alert)
                    flag_mismatch("alert", 32'(report_ch.alert), 32'(head.alert));
                if (report_ch.new_event !== head.new_event)
                    flag_mismatch("new_event", 32'(report_ch.new_event), 32'(head.new_event));
                if (report_ch.bar_level !== head.bar_level)
                    flag_mismatch("bar_level", 32'(report_ch.bar_level), 32'(head.bar_level));
                if (report_ch.peak_rssi !== head.peak_rssi)
                    flag_mismatch("peak_rssi", 32'(report_ch.peak_rssi), 32'(head.peak_rssi));
                if (report_ch.peak_bin !== head.peak_bin)
                    flag_mismatch("peak_bin", 32'(report_ch.peak_bin), 32'(head.peak_bin));
                if (report_ch.busiest_bin !== head.busiest_bin)
                    flag_mismatch("busiest_bin", 32'(report_ch.busiest_bin),
                                  32'(head.busiest_bin));
                if (report_ch.event_count !== head.event_count)
                    flag_mismatch("event_count", report_ch.event_count, head.event_count);
                if (report_ch.duration_ms !== head.duration_ms)
                    flag_mismatch("duration_ms", report_ch.duration_ms, head.duration_ms);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_rf_sweep_activity_monitor: done, errors");
            $finish;
        end
    end

    initial begin
        int tail;
        i_rst_n          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.op     = OP_SAMPLE;
        sample_ch.now_ms = '0;
        sample_ch.rssi   = '0;
        report_ch.ready  = 1'b0;
        reg_ch.valid     = 1'b0;
        reg_ch.index     = CFG_WATCH_MODE;
        reg_ch.data      = '0;
        clock_ms         = '0;
        reset_predictor();

        // directed rows under reset settings: thresholds, bar rounding and clamps,
        // a clear of the peak holds, and a timestamp wrap
        add_row(OP_SAMPLE, 32'd0,   -128, 1, 0,  ST_NONE,   1'b0, 0);
        add_row(OP_SAMPLE, 32'd10,   127, 1, 1,  ST_STRONG, 1'b1, 100);
        add_row(OP_SAMPLE, 32'd20,   -75, 1, 2,  ST_SIGNAL, 1'b1, 43);
        add_row(OP_SAMPLE, 32'd30,   -76, 1, 3,  ST_NONE,   1'b0, 42);
        add_row(OP_SAMPLE, 32'd40,   -45, 1, 4,  ST_STRONG, 1'b1, 81);
        add_row(OP_SAMPLE, 32'd50,   -46, 1, 5,  ST_SIGNAL, 1'b1, 80);
        add_row(OP_SAMPLE, 32'd60,   -30, 1, 6,  ST_STRONG, 1'b1, 100);
        add_row(OP_SAMPLE, 32'd70,   -31, 1, 7,  ST_STRONG, 1'b1, 98);
        add_row(OP_SAMPLE, 32'd80,  -110, 1, 8,  ST_NONE,   1'b0, 0);
        add_row(OP_SAMPLE, 32'd90,  -109, 1, 9,  ST_NONE,   1'b0, 1);
        add_row(OP_SAMPLE, 32'd100,    0, 1, 10, ST_STRONG, 1'b1, 100);
        add_row(OP_CLEAR,  32'd110,    0, 0, 0,  ST_NONE,   1'b0, 0);
        add_row(OP_SAMPLE, 32'd120, -127, 1, 11, ST_NONE,   1'b0, 0);
        add_row(OP_SAMPLE, 32'd130, -126, 1, 12, ST_NONE,   1'b0, 0);
        add_row(OP_SAMPLE, 32'hFFFF_FFFF, 127, 1, 13, ST_STRONG, 1'b1, 100);
        add_row(OP_SAMPLE, 32'h0000_0010, 127, 0, 0, ST_NONE, 1'b0, 0);
        add_row(OP_SAMPLE, 32'h0000_0020, -128, 0, 0, ST_NONE, 1'b0, 0);
        add_row(OP_CLEAR,  32'h0000_0030, -128, 0, 0, ST_NONE, 1'b0, 0);
        add_row(OP_SAMPLE, 32'h0000_0040, -60, 0, 0, ST_NONE, 1'b0, 0);

        // register settings: defaults, bursty watch, both extremes, a minimal window with zero
        // alert gap, zero continuous and hold times, then a random setting across the wrap
        add_setup(1'b0, -75, -45, 30, 1000, 3000, 3000, 2000, 32'd5000, 100);
        add_setup(1'b1, -60, -40, 3, 400, 500, 800, 300, 32'd1000, 100);
        add_setup(1'b1, -128, 127, 0, 0, 0, 0, 0, 32'd0, 60);
        add_setup(1'b0, 127, -128, 65535, 65535, 65535, 65535, 65535, 32'h8000_0000, 60);
        add_setup(1'b1, -90, -50, 1, 1, 100, 65535, 0, 32'd123456, 80);
        add_setup(1'b0, -70, -20, 2, 2000, 0, 0, 1000, 32'd7, 100);
        add_setup(1'($urandom_range(1)), int'($urandom_range(100)) - 100,
                  int'($urandom_range(80)) - 60, $urandom_range(20),
                  $urandom_range(3000, 1), $urandom_range(4000), $urandom_range(4000),
                  $urandom_range(3000), 32'hFFFF_F000, 100);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_request(directed_rows[i]);
        foreach (setups[i]) run_setup(setups[i]);

        // wind down
        sample_ch.valid <= 1'b0;
        tail = 0;
        while (pending_reports.size() != 0 && tail < TAIL_LIMIT) begin
            @(negedge i_clk);
            tail++;
        end
        repeat (SETTLE) @(negedge i_clk);
        if (pending_reports.size() != 0)
            flag_mismatch("reports never delivered", 32'(pending_reports.size()), 32'd0);

        $display("covered %0d requests over %0d register settings, %0d reports checked",
                 samples_taken, setups.size() + 1, reports_seen);
        $display("seen: %0d new events, %0d continuous, %0d unusual, %0d alerts",
                 n_events, n_cont, n_odd, n_alert);
        if (mismatches == 0) begin
            $display("tb_rf_sweep_activity_monitor: done, clean");
        end else begin
            $display("tb_rf_sweep_activity_monitor: done, errors");
        end
        $finish;
    end

endmodule
